// ----- sv/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants for the periodic send scheduler
// Entry layout, function and status codes, controller states.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int MAX_USERS = 64;
  localparam int IDX_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CNT_W     = IDX_W + 1;
  localparam int CHD_W     = IDX_W + 2;

  typedef enum logic [1:0] {
    FN_REG   = 2'd0,
    FN_NEXT  = 2'd1,
    FN_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SENT  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] per;
    logic [31:0] due;
  } entry_t;

  // Ordering key: due time, then id, then period.
  function automatic logic [63:0] entry_key(entry_t e);
    return {e.due, e.id, e.per};
  endfunction

  function automatic logic served_before(entry_t a, entry_t b);
    return entry_key(a) < entry_key(b);
  endfunction

  function automatic logic [31:0] due_advance(entry_t e);
    logic [32:0] sum;
    sum = {1'b0, e.due} + {17'd0, e.per};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

// ----- sv/periodic_send_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_send_scheduler: min-heap scheduler of periodic sends
// Entries live in a heap held in a two-read, one-write synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one command per item; tuser selects it:
//   register a user (tdata = id, period), emit the next send, or clear all.
//   Master channel m_axis returns exactly one item per command: tuser holds
//   the status, tdata the served user id (zero unless status is "sent").
// Processing:
//   Commands are processed one at a time. Each heap level is a RAM read,
//   then a compare and write back; a register item sifts up, a next item
//   reads the root first and then sifts down, and clear, rejected and
//   unused commands go straight to the result stage. tready returns in
//   the cycle after the result loads.
// Reset:
//   The entry count clears at once; the RAM holds no reset state and no
//   entry beyond the count is ever used, so no clearing pass is needed.
// Stalls:
//   The result sits in an output register; a new command is taken while it
//   waits, and that command's result is held until the output register frees.
// ----------------------------------------------------------------------------
module periodic_send_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] user_id, [31:16] period
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] sent_id
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int IDX_W = pss_pkg::IDX_W;
  localparam int CNT_W = pss_pkg::CNT_W;
  localparam int CHD_W = pss_pkg::CHD_W;

  pss_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  pss_pkg::entry_t  val_q, val_d;
  pss_pkg::status_e res_status_q, res_status_d;
  logic [15:0]      res_id_q, res_id_d;

  logic             out_valid_q, out_valid_d;
  pss_pkg::status_e out_status_q, out_status_d;
  logic [15:0]      out_id_q, out_id_d;

  // heap RAM
  pss_pkg::entry_t  entry_mem [pss_pkg::MAX_USERS];
  logic [IDX_W-1:0] ra_a_c, ra_b_c, waddr_c;
  logic             we_c;
  pss_pkg::entry_t  wdata_c;
  pss_pkg::entry_t  rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      entry_mem[waddr_c] <= wdata_c;
    end
    rd_a_q <= entry_mem[ra_a_c];
    rd_b_q <= entry_mem[ra_b_c];
  end

  logic             in_acc;
  logic [CHD_W-1:0] left_c, right_c, cnt_ext;
  logic             left_ok, right_ok;
  logic [IDX_W-1:0] parent_c;
  pss_pkg::entry_t  pick_c;
  logic [IDX_W-1:0] pick_idx_c;
  pss_pkg::entry_t  new_c;

  assign s_axis_tready = (state_q == pss_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign cnt_ext  = {{(CHD_W-CNT_W){1'b0}}, count_q};
  assign left_c   = {1'b0, idx_q, 1'b0} + CHD_W'(1);
  assign right_c  = {1'b0, idx_q, 1'b0} + CHD_W'(2);
  assign left_ok  = left_c < cnt_ext;
  assign right_ok = right_c < cnt_ext;
  assign parent_c = (idx_q - IDX_W'(1)) >> 1;

  always_comb begin
    if (right_ok && pss_pkg::served_before(rd_b_q, rd_a_q)) begin
      pick_c     = rd_b_q;
      pick_idx_c = right_c[IDX_W-1:0];
    end else begin
      pick_c     = rd_a_q;
      pick_idx_c = left_c[IDX_W-1:0];
    end
  end

  always_comb begin
    new_c.id  = s_axis_tdata[15:0];
    new_c.per = s_axis_tdata[31:16];
    new_c.due = {16'd0, s_axis_tdata[31:16]};
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    ra_a_c       = '0;
    ra_b_c       = '0;
    we_c         = 1'b0;
    waddr_c      = idx_q;
    wdata_c      = val_q;

    unique case (state_q)
      pss_pkg::S_IDLE: begin
        // root is read here so it is ready when a next item arrives
        if (in_acc) begin
          res_status_d = pss_pkg::ST_DONE;
          res_id_d     = '0;
          state_d      = pss_pkg::S_FIN;
          unique case (pss_pkg::func_e'(s_axis_tuser))
            pss_pkg::FN_REG: begin
              if (count_q == CNT_W'(pss_pkg::MAX_USERS)) begin
                res_status_d = pss_pkg::ST_FULL;
              end else begin
                val_d   = new_c;
                idx_d   = count_q[IDX_W-1:0];
                count_d = count_q + CNT_W'(1);
                state_d = pss_pkg::S_UP_RD;
              end
            end
            pss_pkg::FN_NEXT: begin
              if (count_q == '0) begin
                res_status_d = pss_pkg::ST_EMPTY;
              end else begin
                state_d = pss_pkg::S_ROOT;
              end
            end
            pss_pkg::FN_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      pss_pkg::S_ROOT: begin
        val_d.id     = rd_a_q.id;
        val_d.per    = rd_a_q.per;
        val_d.due    = pss_pkg::due_advance(rd_a_q);
        res_status_d = pss_pkg::ST_SENT;
        res_id_d     = rd_a_q.id;
        idx_d        = '0;
        state_d      = pss_pkg::S_DN_RD;
      end
      pss_pkg::S_DN_RD: begin
        ra_a_c = left_c[IDX_W-1:0];
        ra_b_c = right_c[IDX_W-1:0];
        if (left_ok) begin
          state_d = pss_pkg::S_DN_CMP;
        end else begin
          we_c    = 1'b1;
          state_d = pss_pkg::S_FIN;
        end
      end
      pss_pkg::S_DN_CMP: begin
        we_c = 1'b1;
        if (pss_pkg::served_before(pick_c, val_q)) begin
          wdata_c = pick_c;
          idx_d   = pick_idx_c;
          state_d = pss_pkg::S_DN_RD;
        end else begin
          state_d = pss_pkg::S_FIN;
        end
      end
      pss_pkg::S_UP_RD: begin
        ra_a_c = parent_c;
        if (idx_q == '0) begin
          we_c    = 1'b1;
          state_d = pss_pkg::S_FIN;
        end else begin
          state_d = pss_pkg::S_UP_CMP;
        end
      end
      pss_pkg::S_UP_CMP: begin
        we_c = 1'b1;
        if (pss_pkg::served_before(val_q, rd_a_q)) begin
          wdata_c = rd_a_q;
          idx_d   = parent_c;
          state_d = pss_pkg::S_UP_RD;
        end else begin
          state_d = pss_pkg::S_FIN;
        end
      end
      pss_pkg::S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          state_d      = pss_pkg::S_IDLE;
        end
      end
      default: state_d = pss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pss_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------- checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(pss_pkg::MAX_USERS))
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_c |-> ({1'b0, waddr_c} < count_q))
    else $error("heap write beyond entry count");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pss_pkg::S_IDLE || state_q == pss_pkg::S_FIN) |-> !we_c)
    else $error("heap write outside a sift");

  a_empty_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == pss_pkg::FN_NEXT && count_q == '0) |=>
    (state_q == pss_pkg::S_FIN && res_status_q == pss_pkg::ST_EMPTY))
    else $error("next on empty store not flagged");

endmodule

// ----- dv/periodic_send_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// periodic_send_scheduler_test: self-checking bench for the send scheduler
// Drives register, next, clear and unused commands over the slave stream,
// predicts every reply with a behavioral copy of the schedule, and compares
// status and sent id of each reply in order. A directed table comes first,
// then random fill/serve episodes, then a short run on one entry with the
// longest period before a fresh entry joins.
// ----------------------------------------------------------------------------
module periodic_send_scheduler_test;

  localparam logic [1:0] FN_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 850;
  localparam int         QUIET_LIMIT  = 4000;
  // serves of the long-period entry before the fresh one is added
  localparam int         LONG_SENDS   = 12;

  typedef struct packed {
    pss_pkg::status_e status;
    logic [15:0]      sent_id;
  } reply_t;

  typedef struct {
    logic [1:0]       fn;
    logic [15:0]      uid;
    logic [15:0]      per;
    bit               typed;
    pss_pkg::status_e status;
    logic [15:0]      sent_id;
  } cmd_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] user_id, [31:16] period
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] sent_id
  logic [1:0]  m_axis_tuser;         // [1:0] status

  periodic_send_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // schedule copy
  pss_pkg::entry_t sched_q [pss_pkg::MAX_USERS];
  int unsigned     sched_cnt = 0;

  reply_t replies_due [$];
  int     mismatches = 0;
  int     replies_checked = 0;
  int     work_items = 0;
  int     n_reg = 0, n_next = 0, n_clear = 0, n_unused = 0, n_full = 0, n_empty = 0;

  bit          sender_gaps = 1'b1;
  int          burst_left = 0;
  logic [15:0] ready_mask = 16'hFFFF;
  logic [3:0]  stall_phase = '0;
  int          quiet_cycles = 0;

  cmd_row_t dir_rows [0:23] = '{
    '{pss_pkg::FN_NEXT,  16'h1234, 16'hABCD, 1'b1, pss_pkg::ST_EMPTY, 16'h0000},  // after reset
    '{FN_UNUSED,         16'hFFFF, 16'hFFFF, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_CLEAR, 16'h0000, 16'h0000, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_REG,   16'hFFFF, 16'hFFFF, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_REG,   16'h0000, 16'h0001, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_REG,   16'h5555, 16'h0000, 1'b1, pss_pkg::ST_DONE,  16'h0000},  // zero period
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b1, pss_pkg::ST_SENT,  16'h5555},
    '{pss_pkg::FN_NEXT,  16'hFFFF, 16'hFFFF, 1'b1, pss_pkg::ST_SENT,  16'h5555},  // due at 0
    '{pss_pkg::FN_REG,   16'hAAAA, 16'h0000, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0F0F, 16'hF0F0, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b1, pss_pkg::ST_EMPTY, 16'h0000},
    '{pss_pkg::FN_REG,   16'h000A, 16'h0005, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_REG,   16'h0003, 16'h0005, 1'b1, pss_pkg::ST_DONE,  16'h0000},  // due tie
    '{pss_pkg::FN_REG,   16'h0007, 16'h0002, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_REG,   16'h0007, 16'h0004, 1'b1, pss_pkg::ST_DONE,  16'h0000},  // id tie
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{FN_UNUSED,         16'h0000, 16'h0000, 1'b1, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000},
    '{pss_pkg::FN_NEXT,  16'h0000, 16'h0000, 1'b0, pss_pkg::ST_DONE,  16'h0000}
  };

  // earlier due wins, then lower id, then shorter period
  function automatic bit goes_first(pss_pkg::entry_t a, pss_pkg::entry_t b);
    if (a.due != b.due) return a.due < b.due;
    if (a.id != b.id) return a.id < b.id;
    return a.per < b.per;
  endfunction

  function automatic reply_t schedule_step(logic [1:0] fn, logic [15:0] uid,
                                           logic [15:0] per);
    reply_t      r;
    int          best;
    logic [32:0] sum;
    r.status  = pss_pkg::ST_DONE;
    r.sent_id = '0;
    case (fn)
      pss_pkg::FN_REG: begin
        if (sched_cnt == pss_pkg::MAX_USERS) begin
          r.status = pss_pkg::ST_FULL;
        end else begin
          sched_q[sched_cnt].id  = uid;
          sched_q[sched_cnt].per = per;
          sched_q[sched_cnt].due = {16'd0, per};
          sched_cnt++;
        end
      end
      pss_pkg::FN_NEXT: begin
        if (sched_cnt == 0) begin
          r.status = pss_pkg::ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < sched_cnt; i++)
            if (goes_first(sched_q[i], sched_q[best])) best = i;
          sum = {1'b0, sched_q[best].due} + {17'd0, sched_q[best].per};
          sched_q[best].due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          r.status  = pss_pkg::ST_SENT;
          r.sent_id = sched_q[best].id;
        end
      end
      pss_pkg::FN_CLEAR: sched_cnt = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rand_id();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) return 16'($urandom_range(0, 7));
    if (pick == 6) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_period();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return 16'($urandom_range(1, 8));
    if (pick == 8) return 16'h0000;
    if (pick == 9) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_item(input logic [1:0] fn, input logic [15:0] uid,
                           input logic [15:0] per, input bit typed = 1'b0,
                           input pss_pkg::status_e st = pss_pkg::ST_DONE,
                           input logic [15:0] sid = '0);
    reply_t want;
    int     gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps ? $urandom_range(1, 9) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {per, uid};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    want = schedule_step(fn, uid, per);
    if (typed) begin
      want.status  = st;
      want.sent_id = sid;
    end
    replies_due.push_back(want);
    case (fn)
      pss_pkg::FN_REG:   n_reg++;
      pss_pkg::FN_NEXT:  n_next++;
      pss_pkg::FN_CLEAR: n_clear++;
      default:           n_unused++;
    endcase
    if (fn != FN_UNUSED) work_items++;
    if (want.status == pss_pkg::ST_FULL) n_full++;
    if (want.status == pss_pkg::ST_EMPTY) n_empty++;
  endtask

  // hold off the sender until every reply is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin
    stall_phase   <= stall_phase + 4'd1;
    m_axis_tready <= ready_mask[stall_phase];
  end

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with nothing outstanding: status %0d sent_id %h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        if (m_axis_tuser != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata != want.sent_id) begin
          $error("sent_id: expected %h, actual %h", want.sent_id, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("periodic_send_scheduler verification failed");
      $finish;
    end
  end

  initial begin
    int random_start;
    int fill;
    int serves;
    int ep;
    repeat (10) @(posedge clk_i);
    rst_ni     <= 1'b1;
    ready_mask <= 16'hB6DB;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].fn, dir_rows[i].uid, dir_rows[i].per,
                dir_rows[i].typed, dir_rows[i].status, dir_rows[i].sent_id);
    drain();

    // random episodes: usually a clear, a fill (sometimes past capacity), then mostly serves
    random_start = work_items;
    ep = 0;
    while (work_items < random_start + RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      if (ep == 0 || $urandom_range(0, 3) != 0)
        send_item(pss_pkg::FN_CLEAR, 16'($urandom), 16'($urandom));
      fill = (ep == 0 || $urandom_range(0, 7) == 0) ?
             pss_pkg::MAX_USERS + $urandom_range(1, 4) : $urandom_range(1, 12);
      for (int k = 0; k < fill; k++) send_item(pss_pkg::FN_REG, rand_id(), rand_period());
      serves = $urandom_range(4, 40);
      for (int k = 0; k < serves; k++) begin
        case ($urandom_range(0, 19))
          0:       send_item(FN_UNUSED, 16'($urandom), 16'($urandom));
          1:       send_item(pss_pkg::FN_REG, rand_id(), rand_period());
          2:       send_item(pss_pkg::FN_CLEAR, 16'($urandom), 16'($urandom));
          default: send_item(pss_pkg::FN_NEXT, 16'($urandom), 16'($urandom));
        endcase
      end
      if ($urandom_range(0, 4) == 0) drain();
      ep++;
    end

    // one entry with the longest period served repeatedly; a fresh entry
    // then has the earlier due time and must win
    drain();
    sender_gaps = 1'b0;
    ready_mask <= 16'hFFFF;
    send_item(pss_pkg::FN_CLEAR, 16'h0000, 16'h0000);
    send_item(pss_pkg::FN_REG, 16'h0100, 16'hFFFF);
    repeat (LONG_SENDS) send_item(pss_pkg::FN_NEXT, 16'($urandom), 16'($urandom));
    send_item(pss_pkg::FN_REG, 16'h0200, 16'hFFFF);
    repeat (4) send_item(pss_pkg::FN_NEXT, 16'($urandom), 16'($urandom));

    drain();
    repeat (40) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      mismatches++;
    end

    $display("Ran %0d commands: %0d register, %0d next, %0d clear, %0d unused func",
             n_reg + n_next + n_clear + n_unused, n_reg, n_next, n_clear, n_unused);
    $display("%0d replies checked, %0d full-store drops, %0d empty-store nexts",
             replies_checked, n_full, n_empty);
    if (mismatches == 0)
      $display("periodic_send_scheduler verification clean");
    else
      $display("periodic_send_scheduler verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pss_pkg.sv
sv/periodic_send_scheduler.sv
dv/periodic_send_scheduler_test.sv
